### sv/assert_macros.svh
// Assertion macros used by the odometer RTL.
// Every macro assumes a clock named clk and an active-low reset named rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define RAO_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When ante holds, cons must hold in the next cycle.
`define RAO_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### sv/rao_pkg.sv
// Shared types, constants and arithmetic helpers for the rotation activity odometer.
// No dependencies.
`default_nettype none

package rao_pkg;

  typedef enum logic [1:0] {
    CMD_ROTATION    = 2'd0,
    CMD_POLL        = 2'd1,
    CMD_END_SESSION = 2'd2,
    CMD_PRELOAD     = 2'd3
  } rao_cmd_t;

  typedef enum logic [1:0] {
    CAUSE_NONE        = 2'd0,
    CAUSE_INTERVAL    = 2'd1,
    CAUSE_LOW_VOLTAGE = 2'd2,
    CAUSE_SESSION_END = 2'd3
  } rao_cause_t;

  // Configuration register indexes
  localparam logic [2:0] REG_LV_SAVE_EN   = 3'd0;
  localparam logic [2:0] REG_LV_THRESHOLD = 3'd1;
  localparam logic [2:0] REG_TIMEOUT      = 3'd2;
  localparam logic [2:0] REG_ROT_PER_SAVE = 3'd3;
  localparam logic [2:0] REG_MIN_SAVE_GAP = 3'd4;
  localparam logic [2:0] REG_GLITCH_FLOOR = 3'd5;

  localparam int CfgIndexW = 3;
  localparam int CfgDataW  = 22;
  localparam int MvW       = 14;
  localparam int AdcW      = 12;

  localparam logic [15:0] TIMEOUT_RST      = 16'd3000;
  localparam logic [19:0] ROT_PER_SAVE_RST = 20'd2500;
  localparam logic [21:0] MIN_SAVE_GAP_RST = 22'd60000;
  localparam logic [13:0] GLITCH_FLOOR_RST = 14'd1500;

  // floor(x/1000) for any 32-bit x: (x * 274877907) >> 38 is exact
  localparam logic [28:0] DIV1000_RECIP = 29'd274877907;
  // adc*9900/4095 == adc*220/91; floor(y/91) == (y * 1474921) >> 27 for y < 2^20
  localparam logic [7:0]  ADC_SCALE_NUM = 8'd220;
  localparam logic [20:0] DIV91_RECIP   = 21'd1474921;

  typedef struct packed {
    logic        lv_save_en;
    logic [13:0] lv_threshold_mv;
    logic [15:0] idle_timeout_ms;
    logic [19:0] rotations_per_save;
    logic [21:0] min_save_gap_ms;
    logic [13:0] glitch_floor_mv;
  } rao_cfg_t;

  typedef struct packed {
    rao_cmd_t    command;
    logic [31:0] time_ms;
    logic [11:0] adc_sample;
    logic [31:0] load_rotations;
    logic [31:0] load_seconds;
    logic [31:0] load_session_number;
  } rao_item_t;

  typedef struct packed {
    logic [31:0] total_rotations;
    logic [31:0] current_session_rotations;
    logic [31:0] total_active_seconds;
    logic [31:0] current_session_seconds;
    logic [31:0] session_number;
    logic        is_active_now;
    logic        save_request;
    rao_cause_t  save_cause;
    logic [13:0] supply_mv;
  } rao_result_t;

  function automatic logic [31:0] div1000(input logic [31:0] x);
    logic [60:0] p;
    p = 61'(x) * 61'(DIV1000_RECIP);
    return {9'd0, p[60:38]};
  endfunction

endpackage

`default_nettype wire

### sv/rao_cfg_regs.sv
// Configuration register bank of the odometer, written through a plain write port.
// Depends on rao_pkg.
`default_nettype none

module rao_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [rao_pkg::CfgIndexW-1:0] cfg_index,
  input  wire logic [rao_pkg::CfgDataW-1:0]  cfg_wdata,
  output rao_pkg::rao_cfg_t                  cfg
);

  rao_pkg::rao_cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        rao_pkg::REG_LV_SAVE_EN:   cfg_nxt.lv_save_en         = cfg_wdata[0];
        rao_pkg::REG_LV_THRESHOLD: cfg_nxt.lv_threshold_mv    = cfg_wdata[13:0];
        rao_pkg::REG_TIMEOUT:      cfg_nxt.idle_timeout_ms    = cfg_wdata[15:0];
        rao_pkg::REG_ROT_PER_SAVE: cfg_nxt.rotations_per_save = cfg_wdata[19:0];
        rao_pkg::REG_MIN_SAVE_GAP: cfg_nxt.min_save_gap_ms    = cfg_wdata[21:0];
        rao_pkg::REG_GLITCH_FLOOR: cfg_nxt.glitch_floor_mv    = cfg_wdata[13:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lv_save_en         <= 1'b0;
      cfg_r.lv_threshold_mv    <= '0;
      cfg_r.idle_timeout_ms    <= rao_pkg::TIMEOUT_RST;
      cfg_r.rotations_per_save <= rao_pkg::ROT_PER_SAVE_RST;
      cfg_r.min_save_gap_ms    <= rao_pkg::MIN_SAVE_GAP_RST;
      cfg_r.glitch_floor_mv    <= rao_pkg::GLITCH_FLOOR_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

### sv/rao_supply_scale.sv
// Converts a raw 12-bit supply ADC sample to millivolts (full scale 9900 mV).
// Depends on rao_pkg.
`default_nettype none

module rao_supply_scale (
  input  wire logic [rao_pkg::AdcW-1:0] adc_sample,
  output logic      [rao_pkg::MvW-1:0]  mv
);

  logic [19:0] scaled;
  logic [40:0] prod;

  // 220 is a constant: shift-and-add, then one reciprocal multiply for /91
  assign scaled = 20'(adc_sample) * 20'(rao_pkg::ADC_SCALE_NUM);
  assign prod   = 41'(scaled) * 41'(rao_pkg::DIV91_RECIP);
  assign mv     = prod[40:27];

endmodule

`default_nettype wire

### sv/rao_core.sv
// Odometer state and per-command update logic; one item per step strobe.
// Depends on rao_pkg, rao_supply_scale and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rao_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step,
  input  wire rao_pkg::rao_item_t item,
  input  wire rao_pkg::rao_cfg_t  cfg,
  output rao_pkg::rao_result_t    res
);

  logic [31:0] life_r, life_nxt;
  logic [31:0] sess_r, sess_nxt;
  logic [31:0] lsec_r, lsec_nxt;
  logic [31:0] ssec_r, ssec_nxt;
  logic [31:0] last_rot_r, last_rot_nxt;
  logic [31:0] start_r, start_nxt;
  logic        open_r, open_nxt;
  logic [31:0] cals_r, cals_nxt;
  logic [31:0] tls_r, tls_nxt;
  logic [13:0] cache_r, cache_nxt;
  logic [31:0] id_r, id_nxt;

  logic [13:0] mv_raw;
  logic [31:0] life_inc;
  logic        int_save;
  logic        lv_save;
  logic [13:0] supply;
  logic [31:0] open_add;
  logic [31:0] closed_secs;

  rao_supply_scale u_scale (
    .adc_sample (item.adc_sample),
    .mv         (mv_raw)
  );

  assign life_inc    = life_r + 32'd1;
  assign closed_secs = rao_pkg::div1000(last_rot_r - start_r);

  always_comb begin
    life_nxt     = life_r;
    sess_nxt     = sess_r;
    lsec_nxt     = lsec_r;
    ssec_nxt     = ssec_r;
    last_rot_nxt = last_rot_r;
    start_nxt    = start_r;
    open_nxt     = open_r;
    cals_nxt     = cals_r;
    tls_nxt      = tls_r;
    cache_nxt    = cache_r;
    id_nxt       = id_r;
    supply       = cache_r;
    int_save     = 1'b0;
    lv_save      = 1'b0;
    res          = '0;

    case (item.command)
      rao_pkg::CMD_ROTATION: begin
        life_nxt     = life_inc;
        sess_nxt     = sess_r + 32'd1;
        last_rot_nxt = item.time_ms;
        if (!open_r) begin
          start_nxt = item.time_ms;
          open_nxt  = 1'b1;
        end
        int_save = (life_inc - cals_r) >= {12'd0, cfg.rotations_per_save};
        if (cfg.lv_save_en) begin
          // low readings are glitches: fall back to the cache when it holds one
          if (mv_raw < cfg.glitch_floor_mv) begin
            supply = (cache_r != '0) ? cache_r : mv_raw;
          end else begin
            supply    = mv_raw;
            cache_nxt = mv_raw;
          end
          lv_save = !int_save && (supply <= cfg.lv_threshold_mv) &&
                    (life_inc != cals_r) &&
                    ((item.time_ms - tls_r) >= {10'd0, cfg.min_save_gap_ms});
        end
        if (int_save || lv_save) begin
          cals_nxt = life_inc;
          tls_nxt  = item.time_ms;
        end
      end
      rao_pkg::CMD_POLL: begin
        if (open_r && ((item.time_ms - last_rot_r) >= {16'd0, cfg.idle_timeout_ms})) begin
          lsec_nxt = lsec_r + closed_secs;
          ssec_nxt = ssec_r + closed_secs;
          open_nxt = 1'b0;
        end
      end
      rao_pkg::CMD_PRELOAD: begin
        life_nxt = item.load_rotations;
        lsec_nxt = item.load_seconds;
        id_nxt   = item.load_session_number;
        sess_nxt = '0;
        ssec_nxt = '0;
        cals_nxt = item.load_rotations;
      end
      default: ;
    endcase

    // report reflects the command's effect, but the counts before a session end
    open_add = open_nxt ? rao_pkg::div1000(item.time_ms - start_nxt) : 32'd0;
    res.total_rotations           = life_nxt;
    res.current_session_rotations = sess_nxt;
    res.total_active_seconds      = lsec_nxt + open_add;
    res.current_session_seconds   = ssec_nxt + open_add;
    res.session_number            = id_nxt;
    res.is_active_now             = open_nxt;
    res.supply_mv                 = supply;
    if (int_save) begin
      res.save_request = 1'b1;
      res.save_cause   = rao_pkg::CAUSE_INTERVAL;
    end else if (lv_save) begin
      res.save_request = 1'b1;
      res.save_cause   = rao_pkg::CAUSE_LOW_VOLTAGE;
    end

    if (item.command == rao_pkg::CMD_END_SESSION) begin
      res.save_request = 1'b1;
      res.save_cause   = rao_pkg::CAUSE_SESSION_END;
      cals_nxt         = life_r;
      tls_nxt          = item.time_ms;
      id_nxt           = id_r + 32'd1;
      sess_nxt         = '0;
      ssec_nxt         = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      life_r     <= '0;
      sess_r     <= '0;
      lsec_r     <= '0;
      ssec_r     <= '0;
      last_rot_r <= '0;
      start_r    <= '0;
      open_r     <= 1'b0;
      cals_r     <= '0;
      tls_r      <= '0;
      cache_r    <= '0;
      id_r       <= 32'd1;
    end else if (step) begin
      life_r     <= life_nxt;
      sess_r     <= sess_nxt;
      lsec_r     <= lsec_nxt;
      ssec_r     <= ssec_nxt;
      last_rot_r <= last_rot_nxt;
      start_r    <= start_nxt;
      open_r     <= open_nxt;
      cals_r     <= cals_nxt;
      tls_r      <= tls_nxt;
      cache_r    <= cache_nxt;
      id_r       <= id_nxt;
    end
  end

  `RAO_ASSERT_ALWAYS(a_cause_iff_save,
    res.save_request == (res.save_cause != rao_pkg::CAUSE_NONE),
    "save cause and request disagree")
  `RAO_ASSERT_NEXT(a_rotation_counts, step && (item.command == rao_pkg::CMD_ROTATION),
    (life_r == $past(life_r) + 32'd1) && open_r,
    "rotation did not count or open a period")
  `RAO_ASSERT_NEXT(a_hold_when_idle, !step,
    $stable(life_r) && $stable(id_r) && $stable(open_r) && $stable(cals_r),
    "state moved without a step")
  `RAO_ASSERT_NEXT(a_session_end, step && (item.command == rao_pkg::CMD_END_SESSION),
    (sess_r == '0) && (ssec_r == '0) && (id_r == $past(id_r) + 32'd1),
    "session end did not start a new session")

endmodule

`default_nettype wire

### sv/rotation_activity_odometer_unit.sv
// Rotation activity odometer. Takes one command per input transfer (tuser carries the
// command) and returns exactly one result transfer per command, in order. Throughput is
// one command per clock unless the output stalls: the item sits in an input register,
// the whole state update (one divide-by-1000 reciprocal multiply on each seconds path,
// one reciprocal multiply for the ADC scaling) settles before the result register, and
// the state feedback closes in that same cycle. The input side keeps accepting while a
// result waits in the output register, stalling only when both hold an item and
// out_tready is low. Configuration writes take effect on the next clock and belong
// between commands only, with no command in flight.
// Depends on rao_pkg, rao_cfg_regs, rao_core.
`default_nettype none

module rotation_activity_odometer_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // [31:0] time_ms, [43:32] adc_sample, [75:44] load_rotations,
  // [107:76] load_seconds, [139:108] load_session_number, [143:140] zero
  input  wire logic [143:0]                  in_tdata,
  // [1:0] command
  input  wire logic [1:0]                    in_tuser,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // [31:0] total_rotations, [63:32] current_session_rotations,
  // [95:64] total_active_seconds, [127:96] current_session_seconds,
  // [159:128] session_number, [160] is_active_now, [161] save_request,
  // [163:162] save_cause, [177:164] supply_mv, [183:178] zero
  output logic [183:0]                       out_tdata,
  input  wire logic                          cfg_we,
  input  wire logic [rao_pkg::CfgIndexW-1:0] cfg_index,
  input  wire logic [rao_pkg::CfgDataW-1:0]  cfg_wdata
);

  rao_pkg::rao_cfg_t    cfg;
  rao_pkg::rao_item_t   item_r, item_nxt;
  rao_pkg::rao_result_t res;
  rao_pkg::rao_result_t res_r, res_nxt;
  logic                 in_v_r, in_v_nxt;
  logic                 out_v_r, out_v_nxt;
  logic                 advance;
  logic                 in_xfer;

  rao_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rao_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  // item moves into the result register when that register is free or being drained
  assign advance   = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || advance;
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    item_nxt = item_r;
    if (in_xfer) begin
      item_nxt.command             = rao_pkg::rao_cmd_t'(in_tuser);
      item_nxt.time_ms             = in_tdata[31:0];
      item_nxt.adc_sample          = in_tdata[43:32];
      item_nxt.load_rotations      = in_tdata[75:44];
      item_nxt.load_seconds        = in_tdata[107:76];
      item_nxt.load_session_number = in_tdata[139:108];
    end
    in_v_nxt = in_xfer ? 1'b1 : (advance ? 1'b0 : in_v_r);

    res_nxt   = advance ? res : res_r;
    out_v_nxt = advance ? 1'b1 : (out_tready ? 1'b0 : out_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {6'd0, res_r.supply_mv, res_r.save_cause, res_r.save_request,
                       res_r.is_active_now, res_r.session_number,
                       res_r.current_session_seconds, res_r.total_active_seconds,
                       res_r.current_session_rotations, res_r.total_rotations};

endmodule

`default_nettype wire

### test/tb_rotation_activity_odometer_unit.sv
// Self-checking testbench for rotation_activity_odometer_unit: directed and random commands
// over several register settings, each result checked against an in-bench odometer tracker.
// Depends on rao_pkg and the RTL of the unit.

module tb_rotation_activity_odometer_unit;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 300;
  localparam int PHASE_ITEMS = 165;

  // Tracks the odometer state and holds the reports the unit still owes.
  class odometer_tracker;
    rao_pkg::rao_cfg_t    cfg;
    logic [31:0] life_rot, sess_rot, life_secs, sess_secs;
    logic [31:0] last_rot_ms, period_start_ms, rot_at_save, ms_at_save, sess_number;
    logic        period_open;
    logic [13:0] cached_mv;
    rao_pkg::rao_result_t pending_reports[$];
    int unsigned reports_seen;
    int unsigned errors;

    function new();
      cfg.lv_save_en         = 1'b0;
      cfg.lv_threshold_mv    = '0;
      cfg.idle_timeout_ms    = rao_pkg::TIMEOUT_RST;
      cfg.rotations_per_save = rao_pkg::ROT_PER_SAVE_RST;
      cfg.min_save_gap_ms    = rao_pkg::MIN_SAVE_GAP_RST;
      cfg.glitch_floor_mv    = rao_pkg::GLITCH_FLOOR_RST;
      life_rot = '0; sess_rot = '0; life_secs = '0; sess_secs = '0;
      last_rot_ms = '0; period_start_ms = '0; rot_at_save = '0; ms_at_save = '0;
      sess_number = 32'd1;
      period_open = 1'b0;
      cached_mv = '0;
      reports_seen = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [rao_pkg::CfgIndexW-1:0] idx,
                          logic [rao_pkg::CfgDataW-1:0] val);
      case (idx)
        rao_pkg::REG_LV_SAVE_EN:   cfg.lv_save_en         = val[0];
        rao_pkg::REG_LV_THRESHOLD: cfg.lv_threshold_mv    = val[13:0];
        rao_pkg::REG_TIMEOUT:      cfg.idle_timeout_ms    = val[15:0];
        rao_pkg::REG_ROT_PER_SAVE: cfg.rotations_per_save = val[19:0];
        rao_pkg::REG_MIN_SAVE_GAP: cfg.min_save_gap_ms    = val[21:0];
        rao_pkg::REG_GLITCH_FLOOR: cfg.glitch_floor_mv    = val[13:0];
        default: ;
      endcase
    endfunction

    // whole seconds between two wrapping timestamps
    function logic [31:0] secs_between(logic [31:0] from_ms, logic [31:0] to_ms);
      logic [31:0] span;
      span = to_ms - from_ms;
      return span / 32'd1000;
    endfunction

    // low readings are glitches: fall back to the last good reading if there is one
    function logic [13:0] filtered_mv(logic [11:0] adc);
      logic [31:0] mv;
      mv = (32'(adc) * 32'd9900) / 32'd4095;
      if (mv < 32'(cfg.glitch_floor_mv)) return (cached_mv != '0) ? cached_mv : mv[13:0];
      cached_mv = mv[13:0];
      return cached_mv;
    endfunction

    function void mark_saved(logic [31:0] now);
      rot_at_save = life_rot;
      ms_at_save  = now;
    endfunction

    function void take_command(rao_pkg::rao_item_t it);
      rao_pkg::rao_result_t r;
      logic [31:0] now, span, open_secs;
      now = it.time_ms;
      r.save_request = 1'b0;
      r.save_cause   = rao_pkg::CAUSE_NONE;
      r.supply_mv    = cached_mv;
      case (it.command)
        rao_pkg::CMD_ROTATION: begin
          life_rot++;
          sess_rot++;
          last_rot_ms = now;
          if (!period_open) begin
            period_start_ms = now;
            period_open = 1'b1;
          end
          span = life_rot - rot_at_save;
          if (span >= 32'(cfg.rotations_per_save)) begin
            mark_saved(now);
            r.save_request = 1'b1;
            r.save_cause   = rao_pkg::CAUSE_INTERVAL;
          end
          if (cfg.lv_save_en) begin
            r.supply_mv = filtered_mv(it.adc_sample);
            span = now - ms_at_save;
            if (r.supply_mv <= cfg.lv_threshold_mv && life_rot != rot_at_save &&
                span >= 32'(cfg.min_save_gap_ms)) begin
              mark_saved(now);
              r.save_request = 1'b1;
              r.save_cause   = rao_pkg::CAUSE_LOW_VOLTAGE;
            end
          end
        end
        rao_pkg::CMD_POLL: begin
          span = now - last_rot_ms;
          if (period_open && span >= 32'(cfg.idle_timeout_ms)) begin
            // period is measured up to the last rotation, not to the poll
            open_secs = secs_between(period_start_ms, last_rot_ms);
            life_secs += open_secs;
            sess_secs += open_secs;
            period_open = 1'b0;
          end
        end
        rao_pkg::CMD_PRELOAD: begin
          life_rot    = it.load_rotations;
          life_secs   = it.load_seconds;
          sess_number = it.load_session_number;
          sess_rot    = '0;
          sess_secs   = '0;
          rot_at_save = it.load_rotations;
        end
        default: ;
      endcase
      open_secs = period_open ? secs_between(period_start_ms, now) : '0;
      r.total_rotations           = life_rot;
      r.current_session_rotations = sess_rot;
      r.total_active_seconds      = life_secs + open_secs;
      r.current_session_seconds   = sess_secs + open_secs;
      r.session_number            = sess_number;
      r.is_active_now             = period_open;
      // session end reports the closing counts, then starts a fresh session
      if (it.command == rao_pkg::CMD_END_SESSION) begin
        mark_saved(now);
        r.save_request = 1'b1;
        r.save_cause   = rao_pkg::CAUSE_SESSION_END;
        sess_number++;
        sess_rot  = '0;
        sess_secs = '0;
      end
      pending_reports.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("result %0d %s got %h want %h", reports_seen, name, got, want));
    endtask

    task check_report(logic [183:0] data);
      rao_pkg::rao_result_t want;
      if (pending_reports.size() == 0) begin
        report($sformatf("result %0d arrived with nothing outstanding", reports_seen));
      end else begin
        want = pending_reports.pop_front();
        check_field("total_rotations", data[31:0], want.total_rotations);
        check_field("current_session_rotations", data[63:32], want.current_session_rotations);
        check_field("total_active_seconds", data[95:64], want.total_active_seconds);
        check_field("current_session_seconds", data[127:96], want.current_session_seconds);
        check_field("session_number", data[159:128], want.session_number);
        check_field("is_active_now", 32'(data[160]), 32'(want.is_active_now));
        check_field("save_request", 32'(data[161]), 32'(want.save_request));
        check_field("save_cause", 32'(data[163:162]), 32'(want.save_cause));
        check_field("supply_mv", 32'(data[177:164]), 32'(want.supply_mv));
      end
      reports_seen++;
    endtask
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_tvalid = 1'b0;
  logic                          in_tready;
  logic [143:0]                  in_tdata = '0;
  logic [1:0]                    in_tuser = '0;
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [183:0]                  out_tdata;
  logic                          cfg_we = 1'b0;
  logic [rao_pkg::CfgIndexW-1:0] cfg_index = '0;
  logic [rao_pkg::CfgDataW-1:0]  cfg_wdata = '0;

  odometer_tracker tracker = new();

  int unsigned cycle_count = 0;
  int          stall_pct = 0;
  int          hold_requests = 0;
  int          holds_served = 0;
  int          hold_left = 0;
  int          burst_left = 0;
  bit          sender_gaps = 1'b0;
  logic [31:0] clock_ms = '0;
  logic [15:0] cur_timeout = rao_pkg::TIMEOUT_RST;

  // lv_save_en, threshold, timeout, rotations_per_save, min_save_gap, glitch_floor
  int unsigned phase_cfg [7][6] = '{
    '{0, 0,    3000,  2500,    60000,   1500},
    '{1, 9900, 1,     1,       0,       0},
    '{1, 3000, 3000,  7,       5000,    1500},
    '{0, 0,    65535, 1000000, 3600000, 9900},
    '{1, 9900, 0,     0,       0,       9900},
    '{1, 4000, 500,   13,      200,     2000},
    '{1, 0,    2500,  50,      1000,    0}
  };

  rotation_activity_odometer_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side: check each transfer, then pick the next ready value
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.check_report(out_tdata);
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (holds_served != hold_requests) begin
      holds_served++;
      hold_left = LONG_HOLD;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_command(rao_pkg::rao_item_t it);
    int gap;
    if (sender_gaps && burst_left == 0) begin
      gap = $urandom_range(0, 6);
      burst_left = $urandom_range(1, 16);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= it.command;
    in_tdata  <= {4'd0, it.load_session_number, it.load_seconds, it.load_rotations,
                  it.adc_sample, it.time_ms};
    clock_ms = it.time_ms;
    do @(posedge clk); while (!in_tready);
    tracker.take_command(it);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (tracker.pending_reports.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(logic [rao_pkg::CfgIndexW-1:0] idx, int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= rao_pkg::CfgDataW'(val);
    tracker.set_reg(idx, rao_pkg::CfgDataW'(val));
    @(posedge clk);
  endtask

  task automatic apply_settings(int p);
    wait_drained();
    write_reg(rao_pkg::REG_LV_SAVE_EN,   phase_cfg[p][0]);
    write_reg(rao_pkg::REG_LV_THRESHOLD, phase_cfg[p][1]);
    write_reg(rao_pkg::REG_TIMEOUT,      phase_cfg[p][2]);
    write_reg(rao_pkg::REG_ROT_PER_SAVE, phase_cfg[p][3]);
    write_reg(rao_pkg::REG_MIN_SAVE_GAP, phase_cfg[p][4]);
    write_reg(rao_pkg::REG_GLITCH_FLOOR, phase_cfg[p][5]);
    cfg_we <= 1'b0;
    @(posedge clk);
    cur_timeout = 16'(phase_cfg[p][2]);
  endtask

  function automatic rao_pkg::rao_item_t make_item(rao_pkg::rao_cmd_t cmd, logic [31:0] t,
                                                   logic [11:0] adc,
                                                   logic [31:0] lr = '0,
                                                   logic [31:0] ls = '0,
                                                   logic [31:0] ln = '0);
    rao_pkg::rao_item_t it;
    it.command = cmd;
    it.time_ms = t;
    it.adc_sample = adc;
    it.load_rotations = lr;
    it.load_seconds = ls;
    it.load_session_number = ln;
    return it;
  endfunction

  // mostly short steps in time, some past the timeout, a few long or wrapping jumps
  function automatic rao_pkg::rao_item_t random_item();
    rao_pkg::rao_item_t it;
    int unsigned        pick;
    logic [31:0]        delta;
    pick = $urandom_range(99);
    if (pick < 58)      it.command = rao_pkg::CMD_ROTATION;
    else if (pick < 84) it.command = rao_pkg::CMD_POLL;
    else if (pick < 92) it.command = rao_pkg::CMD_END_SESSION;
    else                it.command = rao_pkg::CMD_PRELOAD;
    pick = $urandom_range(99);
    if (pick < 55)      delta = $urandom_range(0, 400);
    else if (pick < 82) delta = $urandom_range(0, 2 * cur_timeout + 10);
    else if (pick < 96) delta = $urandom_range(0, 250000);
    else                delta = $urandom();
    it.time_ms = clock_ms + delta;
    it.adc_sample = ($urandom_range(3) == 0) ? 12'($urandom_range(0, 700)) : 12'($urandom());
    it.load_rotations = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 40)
                                                 : $urandom();
    it.load_seconds = $urandom();
    it.load_session_number = ($urandom_range(7) == 0) ? 32'hFFFF_FFFF : $urandom();
    return it;
  endfunction

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values first
    send_command(make_item(rao_pkg::CMD_ROTATION, 32'd100, 12'd4095));
    send_command(make_item(rao_pkg::CMD_POLL, 32'd200, 12'd0));
    send_command(make_item(rao_pkg::CMD_END_SESSION, 32'd300, 12'd0));

    wait_drained();
    write_reg(rao_pkg::REG_LV_SAVE_EN, 1);
    write_reg(rao_pkg::REG_LV_THRESHOLD, 5000);
    write_reg(rao_pkg::REG_TIMEOUT, 3000);
    write_reg(rao_pkg::REG_ROT_PER_SAVE, 3);
    write_reg(rao_pkg::REG_MIN_SAVE_GAP, 1000);
    write_reg(rao_pkg::REG_GLITCH_FLOOR, 1500);
    cfg_we <= 1'b0;
    @(posedge clk);

    // glitch with empty cache, full scale, glitch replaced by cache, interval save
    send_command(make_item(rao_pkg::CMD_ROTATION, 32'd1000, 12'd0));
    send_command(make_item(rao_pkg::CMD_ROTATION, 32'd1500, 12'd4095));
    send_command(make_item(rao_pkg::CMD_ROTATION, 32'd2600, 12'd100));
    // poll early, poll after timeout, poll with nothing open
    send_command(make_item(rao_pkg::CMD_POLL, 32'd4000, 12'd0));
    send_command(make_item(rao_pkg::CMD_POLL, 32'd5600, 12'd0));
    send_command(make_item(rao_pkg::CMD_POLL, 32'd9000, 12'd0));
    // low supply reading leads to a low-voltage save
    send_command(make_item(rao_pkg::CMD_ROTATION, 32'd10000, 12'd1000));
    send_command(make_item(rao_pkg::CMD_ROTATION, 32'd12000, 12'd1800));
    send_command(make_item(rao_pkg::CMD_END_SESSION, 32'd13500, 12'd0));
    send_command(make_item(rao_pkg::CMD_ROTATION, 32'd14000, 12'd2047));
    // preload near wrap: lifetime count and session number roll over
    send_command(make_item(rao_pkg::CMD_PRELOAD, 32'd15000, 12'd0,
                           32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_command(make_item(rao_pkg::CMD_ROTATION, 32'd16000, 12'd4095));
    send_command(make_item(rao_pkg::CMD_ROTATION, 32'd16500, 12'd4095));
    send_command(make_item(rao_pkg::CMD_END_SESSION, 32'd17000, 12'd0));
    // long gap without a poll, then the timestamp wraps
    send_command(make_item(rao_pkg::CMD_ROTATION, 32'hFFFF_FF00, 12'd2800));
    send_command(make_item(rao_pkg::CMD_ROTATION, 32'h0000_0100, 12'd2800));
    send_command(make_item(rao_pkg::CMD_POLL, 32'h0000_2000, 12'd0));
    send_command(make_item(rao_pkg::CMD_PRELOAD, 32'h0000_3000, 12'd0));
    send_command(make_item(rao_pkg::CMD_ROTATION, 32'h0000_3100, 12'd4095));

    for (int p = 0; p < 7; p++) begin
      apply_settings(p);
      stall_pct = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 35 : 70;
      sender_gaps = (p != 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // long receiver hold-off while the sender keeps offering
        if ((p == 2 || p == 5) && n == 80) hold_requests++;
        send_command(random_item());
      end
    end

    wait_drained();
    if (tracker.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
